>>> src/first_substring_match_top_macros.svh
// Assertion macros shared by the substring search RTL.
`ifndef FIRST_SUBSTRING_MATCH_TOP_MACROS_SVH
`define FIRST_SUBSTRING_MATCH_TOP_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define FSUBM_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("fsubm assertion failed");

// Next-cycle implication, checked out of reset.
`define FSUBM_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("fsubm assertion failed");

`endif

>>> src/fsubm_pkg.sv
// Package: sizes, types, register codes and helpers of the substring search.
`default_nettype none
package fsubm_pkg;

  localparam int MAX_NEEDLE  = 16;
  localparam int OFFSET_BITS = 32;

  // Longest needle the compare supports.
  localparam int CAP       = (MAX_NEEDLE < 16) ? MAX_NEEDLE : 16;
  localparam int WIN_DEPTH = CAP - 1;
  localparam int LEN_W     = $clog2(CAP + 1);

  // Queue between front and back.
  localparam int Q_DEPTH = 4;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);

  // Config port.
  localparam int ADDR_W = 5;
  localparam int DATA_W = 64;

  localparam logic [1:0] REG_FIRST  = 2'd0;
  localparam logic [1:0] REG_NEXT   = 2'd1;
  localparam logic [1:0] REG_LENGTH = 2'd2;

  typedef struct packed {
    logic [7:0] hay;
    logic       last;
  } hay_word_t;

  typedef struct packed {
    logic [63:0] first;
    logic [63:0] next;
    logic [4:0]  length;
  } needle_cfg_t;

  // Byte idx of the 16-byte needle.
  function automatic logic [7:0] needle_byte(needle_cfg_t cfg, logic [3:0] idx);
    logic [127:0] all;
    all = {cfg.next, cfg.first};
    return all[{idx, 3'b000} +: 8];
  endfunction

endpackage
`default_nettype wire

>>> src/first_substring_match_top.sv
// Top level: streaming first-occurrence substring search with APB config.
//
// Haystack words (hay_byte, last_byte) enter on in_valid/in_ready, one per
// clock while in_ready is high. Each haystack yields exactly one result word
// on out_valid/out_ready: found=1 with the offset of the needle's first byte,
// or found=0, offset=0 when the last byte passes without a match. Bytes after
// a match are dropped up to and including the last byte of that haystack.
// An accepted byte passes a queue slot, then the result register, before its
// result word shows on out_valid. The back end's 16-byte window compare is
// combinational; it takes one byte per clock while bytes are queued and no
// result is stalled. A four-word queue sits between the front end and the
// matcher, and the result register lets the matcher keep going until a result
// is stalled; a stalled result then fills the queue and in_ready drops.
// Needle registers sit on the APB port at 0x00, 0x08 and 0x10 (64-bit data)
// and the user must write them only while the block is idle (not enforced).
// Synchronous reset (rst) clears the needle, the queue, the offset counter
// and the output valid.
`default_nettype none
module first_substring_match_top
  import fsubm_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [7:0]        hay_byte,
  input  wire logic              last_byte,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic                   found,
  output logic [31:0]            offset,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0]      prdata,
  output logic                   pready
);

  needle_cfg_t cfg;
  logic        cfg_write;
  logic [1:0]  reg_sel;
  logic        q_valid;
  hay_word_t   q_word;
  logic        q_pop;

  assign pready    = 1'b1;
  assign reg_sel   = paddr[4:3];
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_write) begin
      case (reg_sel)
        REG_FIRST:  cfg.first  <= pwdata;
        REG_NEXT:   cfg.next   <= pwdata;
        REG_LENGTH: cfg.length <= pwdata[4:0];
        default:    ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_FIRST:  prdata = cfg.first;
      REG_NEXT:   prdata = cfg.next;
      REG_LENGTH: prdata = DATA_W'(cfg.length);
      default:    prdata = '0;
    endcase
  end

  fsubm_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .hay_byte  (hay_byte),
    .last_byte (last_byte),
    .q_valid   (q_valid),
    .q_word    (q_word),
    .q_pop     (q_pop)
  );

  fsubm_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .q_valid   (q_valid),
    .q_word    (q_word),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .found     (found),
    .offset    (offset)
  );

endmodule
`default_nettype wire

>>> src/fsubm_front.sv
// Front end: accepts haystack words and queues them for the matcher.
`default_nettype none
module fsubm_front
  import fsubm_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] hay_byte,
  input  wire logic       last_byte,
  output logic            q_valid,
  output hay_word_t       q_word,
  input  wire logic       q_pop
);

  hay_word_t            slots [Q_DEPTH];
  logic [Q_PTR_W-1:0]   wr_ptr;
  logic [Q_PTR_W-1:0]   rd_ptr;
  logic [Q_PTR_W:0]     count;
  logic                 push;
  logic                 pop;

  assign in_ready = (count != (Q_PTR_W+1)'(Q_DEPTH));
  assign q_valid  = (count != '0);
  assign q_word   = slots[rd_ptr];
  assign push     = in_valid && in_ready;
  assign pop      = q_pop && q_valid;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= '{hay: hay_byte, last: last_byte};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

`include "first_substring_match_top_macros.svh"

  `FSUBM_ASSERT_NOW(a_q_bound, 1'b1, count <= (Q_PTR_W+1)'(Q_DEPTH))
  `FSUBM_ASSERT_NEXT(a_q_fill, push && !pop, count == $past(count) + 1'b1)

endmodule
`default_nettype wire

>>> src/fsubm_back.sv
// Back end: window compare, offset count and result register.
`default_nettype none
module fsubm_back
  import fsubm_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire needle_cfg_t cfg,
  input  wire logic        q_valid,
  input  wire hay_word_t   q_word,
  output logic             q_pop,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             found,
  output logic [31:0]      offset
);

  logic [7:0]             window [WIN_DEPTH];
  logic [OFFSET_BITS-1:0] bytes_seen;
  logic                   match_reported;

  logic                   take;
  logic [LEN_W-1:0]       len_eff;
  logic [7:0]             cur [CAP];
  logic                   hit;
  logic                   eligible;
  logic [OFFSET_BITS-1:0] len_m1;
  logic [OFFSET_BITS-1:0] off;
  logic                   off_fits;
  logic                   res_valid;
  logic                   res_found;
  logic [31:0]            res_offset;

  assign take  = q_valid && (!out_valid || out_ready);
  assign q_pop = take;

  // Length above capacity counts as capacity.
  always_comb begin
    if (cfg.length > 5'(CAP)) begin
      len_eff = LEN_W'(CAP);
    end else begin
      len_eff = cfg.length[LEN_W-1:0];
    end
  end

  // cur[0] is the incoming byte, cur[k] the byte k places back.
  always_comb begin
    cur[0] = q_word.hay;
    for (int k = 1; k < CAP; k++) begin
      cur[k] = window[k-1];
    end
  end

  // Needle byte len-1-k lines up with cur[k].
  always_comb begin
    logic [4:0] jj;
    hit = 1'b1;
    for (int k = 0; k < CAP; k++) begin
      jj = 5'(len_eff) - 5'd1 - 5'(k);
      if (5'(k) < 5'(len_eff)) begin
        if (needle_byte(cfg, jj[3:0]) != cur[k]) begin
          hit = 1'b0;
        end
      end
    end
  end

  assign len_m1   = OFFSET_BITS'(len_eff) - OFFSET_BITS'(1);
  assign eligible = (bytes_seen != '1) && (bytes_seen >= len_m1);
  assign off      = bytes_seen - len_m1;
  assign off_fits = (64'(off) <= 64'h0000_0000_FFFF_FFFF);

  always_comb begin
    res_valid  = 1'b0;
    res_found  = 1'b0;
    res_offset = '0;
    if (!match_reported) begin
      if (len_eff == '0) begin
        res_valid = 1'b1;
        res_found = 1'b1;
      end else if (eligible && hit && off_fits) begin
        res_valid  = 1'b1;
        res_found  = 1'b1;
        res_offset = 32'(off);
      end
      if (q_word.last && !res_found) begin
        res_valid = 1'b1;
      end
    end
  end

  // Window is not cleared per haystack; the compare reads only current bytes.
  always_ff @(posedge clk) begin
    if (take && !match_reported) begin
      window[0] <= q_word.hay;
      for (int i = 1; i < WIN_DEPTH; i++) begin
        window[i] <= window[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_seen     <= '0;
      match_reported <= 1'b0;
      out_valid      <= 1'b0;
    end else begin
      if (take) begin
        out_valid <= res_valid;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (take) begin
        if (q_word.last) begin
          bytes_seen     <= '0;
          match_reported <= 1'b0;
        end else if (!match_reported) begin
          if (bytes_seen != '1) begin
            bytes_seen <= bytes_seen + 1'b1;
          end
          match_reported <= res_found;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take && res_valid) begin
      found  <= res_found;
      offset <= res_offset;
    end
  end

`include "first_substring_match_top_macros.svh"

  `FSUBM_ASSERT_NEXT(a_clear_on_last, take && q_word.last,
                     (bytes_seen == '0) && !match_reported)
  `FSUBM_ASSERT_NEXT(a_match_sticks, take && !q_word.last && res_valid, match_reported)
  `FSUBM_ASSERT_NOW(a_miss_zero, out_valid && !found, offset == '0)

endmodule
`default_nettype wire

>>> verif/first_substring_match_top_tb.sv
// Testbench for first_substring_match_top: directed table plus random haystacks, self-checked.
`default_nettype none
module first_substring_match_top_tb;
  import fsubm_pkg::*;

  // Random part stops once this many words were sent in total
  // (bytes dropped after a hit count as well).
  localparam int ITEM_TARGET   = 1400;
  // Settle margin covering the four-word queue and the result register.
  localparam int SETTLE_CYCLES = 12;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int PLAN_ROWS     = 34;

  typedef struct packed {
    logic        found;
    logic [31:0] offset;
  } match_word_t;

  typedef enum logic [1:0] {
    ROW_WORD,
    ROW_REG
  } row_kind_t;

  typedef struct {
    row_kind_t   kind;
    logic [1:0]  reg_idx;
    logic [63:0] value;
    logic [7:0]  hay;
    logic        last;
    bit          typed;
    match_word_t want;
  } plan_row_t;

  logic              clk;
  logic              rst       = 1'b1;
  logic              in_valid  = 1'b0;
  logic              in_ready;
  logic [7:0]        hay_byte  = '0;
  logic              last_byte = 1'b0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic              found;
  logic [31:0]       offset;
  logic              psel      = 1'b0;
  logic              penable   = 1'b0;
  logic              pwrite    = 1'b0;
  logic [ADDR_W-1:0] paddr     = '0;
  logic [DATA_W-1:0] pwdata    = '0;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  first_substring_match_top i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .hay_byte  (hay_byte),
    .last_byte (last_byte),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .found     (found),
    .offset    (offset),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Scan predictor: its own copy of the needle registers and of the haystack
  // state (recent bytes, byte count, hit flag).
  // ---------------------------------------------------------------------------
  needle_cfg_t needle = '0;
  logic [7:0]  recent [WIN_DEPTH];   // entry 0 is the newest byte
  logic [31:0] seen_cnt;
  bit          reported;

  match_word_t expected_matches [$];

  int  errors       = 0;
  int  results_seen = 0;
  int  live_words   = 0;
  int  sent_words   = 0;
  int  haystacks    = 0;
  int  phases       = 0;
  int  cycle_count  = 0;
  bit  steady       = 1'b0;    // no idling on either side while set

  function automatic void clear_scan();
    foreach (recent[i]) recent[i] = '0;
    seen_cnt = '0;
    reported = 1'b0;
  endfunction

  // Takes one byte, returns 1 when it produces a result word.
  function automatic bit scan_byte(input logic [7:0] b, input logic l,
                                   output match_word_t w);
    logic [127:0] pat;
    int unsigned  len;
    bit           hit;
    bit           made;
    made = 1'b0;
    w    = '0;
    pat  = {needle.next, needle.first};
    if (!reported) begin
      // Over-length needles behave as full-length ones.
      len = (needle.length > CAP) ? CAP : needle.length;
      if (len == 0) begin
        // Empty needle hits on the first live byte.
        w.found  = 1'b1;
        w.offset = '0;
        reported = 1'b1;
        made     = 1'b1;
      end else if (seen_cnt != '1 && seen_cnt >= len - 1) begin
        // Needle ends at this byte: last needle byte vs the new byte,
        // earlier needle bytes vs the window, newest first.
        hit = (pat[8*(len-1) +: 8] == b);
        for (int i = 1; i < len; i++)
          if (pat[8*(len-1-i) +: 8] != recent[i-1]) hit = 1'b0;
        if (hit) begin
          w.found  = 1'b1;
          w.offset = seen_cnt - (len - 1);
          reported = 1'b1;
          made     = 1'b1;
        end
      end
      for (int i = WIN_DEPTH - 1; i > 0; i--) recent[i] = recent[i-1];
      recent[0] = b;
      if (seen_cnt != '1) seen_cnt++;   // saturates: no hit once pinned
      if (l && !reported) begin
        w    = '0;
        made = 1'b1;
      end
    end
    if (l) clear_scan();
    return made;
  endfunction

  // ---------------------------------------------------------------------------
  // Bus and stream drivers
  // ---------------------------------------------------------------------------

  // Setup then access phase; leaves psel up so writes can go back to back.
  task automatic write_reg(input logic [1:0] idx, input logic [63:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      REG_FIRST:  needle.first  = value;
      REG_NEXT:   needle.next   = value;
      REG_LENGTH: needle.length = value[4:0];
      default: ;
    endcase
  endtask

  task automatic release_bus();
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Sender pause: stop, wait for every outstanding result, then give the
  // back end time to finish any byte that produced no result.
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_matches.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Offers one word, waits for the handshake, then runs the predictor.
  // A typed row supplies its own expected word instead of the predictor's.
  task automatic send_word(input logic [7:0] b, input logic l, input bit typed,
                           input match_word_t typed_word);
    match_word_t w;
    bit          live;
    bit          made;
    while (!steady && $urandom_range(99) < 26) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    hay_byte  <= b;
    last_byte <= l;
    do @(posedge clk); while (!in_ready);
    live = !reported;
    made = scan_byte(b, l, w);
    if (typed) expected_matches.push_back(typed_word);
    else if (made) expected_matches.push_back(w);
    if (live) live_words++;
    sent_words++;
    if (l) haystacks++;
    steady <= (live_words >= 500 && live_words < 800);
  endtask

  // ---------------------------------------------------------------------------
  // Directed table
  // ---------------------------------------------------------------------------
  function automatic plan_row_t word_row(input logic [7:0] b, input logic l);
    plan_row_t row;
    row       = '{kind: ROW_WORD, reg_idx: '0, value: '0, hay: b, last: l,
                  typed: 1'b0, want: '0};
    return row;
  endfunction

  function automatic plan_row_t check_row(input logic [7:0] b, input logic l,
                                          input logic f, input logic [31:0] off);
    plan_row_t row;
    row       = word_row(b, l);
    row.typed = 1'b1;
    row.want  = '{found: f, offset: off};
    return row;
  endfunction

  function automatic plan_row_t reg_row(input logic [1:0] idx, input logic [63:0] v);
    plan_row_t row;
    row         = word_row('0, 1'b0);
    row.kind    = ROW_REG;
    row.reg_idx = idx;
    row.value   = v;
    return row;
  endfunction

  plan_row_t plan [PLAN_ROWS];

  initial begin : stimulus
    bit           on_bus;
    int           r;
    int           pick;
    int           len;
    int           eff;
    int           n;
    int           at;
    logic [63:0]  first_v;
    logic [63:0]  next_v;
    logic [127:0] pat;
    logic [7:0]   alpha [4];
    logic [7:0]   hay [$];

    plan = '{
      // Reset needle is empty: first byte hits at 0, the rest is dropped.
      check_row(8'h00, 1'b0, 1'b1, 32'd0),
      word_row (8'hFF, 1'b1),
      // Needle "abc" ; haystack "axabc" + 'z' (dropped after the hit).
      reg_row  (REG_FIRST, 64'h0000_0000_0063_6261),
      reg_row  (REG_LENGTH, 64'd3),
      word_row (8'h61, 1'b0), word_row(8'h78, 1'b0),
      word_row (8'h61, 1'b0), word_row(8'h62, 1'b0),
      check_row(8'h63, 1'b0, 1'b1, 32'd2),
      word_row (8'h7A, 1'b1),
      // One-byte haystack, shorter than the needle: not found.
      check_row(8'h63, 1'b1, 1'b0, 32'd0),
      // Needle cut to "ab" in the middle of "qa..": 'b' completes it at 1.
      word_row (8'h71, 1'b0), word_row(8'h61, 1'b0),
      reg_row  (REG_LENGTH, 64'd2),
      check_row(8'h62, 1'b1, 1'b1, 32'd1),
      // All-ones needle, length register at its top (clamped to 16).
      reg_row  (REG_FIRST, '1),
      reg_row  (REG_NEXT, '1),
      reg_row  (REG_LENGTH, 64'd31),
      word_row (8'hFF, 1'b0), word_row(8'hFF, 1'b0), word_row(8'hFF, 1'b0),
      word_row (8'hFF, 1'b0), word_row(8'hFF, 1'b0), word_row(8'hFF, 1'b0),
      word_row (8'hFF, 1'b0), word_row(8'hFF, 1'b0), word_row(8'hFF, 1'b0),
      word_row (8'hFF, 1'b0), word_row(8'hFF, 1'b0), word_row(8'hFF, 1'b0),
      word_row (8'hFF, 1'b0), word_row(8'hFF, 1'b0), word_row(8'hFF, 1'b0),
      check_row(8'hFF, 1'b1, 1'b1, 32'd0)
    };

    needle = '0;
    clear_scan();
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    on_bus = 1'b0;
    foreach (plan[i]) begin
      if (plan[i].kind == ROW_REG) begin
        if (!on_bus) settle();
        write_reg(plan[i].reg_idx, plan[i].value);
        on_bus = 1'b1;
      end else begin
        if (on_bus) release_bus();
        on_bus = 1'b0;
        send_word(plan[i].hay, plan[i].last, plan[i].typed, plan[i].want);
      end
    end

    // Random phases: new needle settings, then a few haystacks each. Most
    // haystacks carry the needle (sometimes with one bit flipped) among
    // bytes drawn from the needle itself, so near misses are common.
    while (sent_words < ITEM_TARGET) begin
      settle();
      phases++;
      foreach (alpha[i]) alpha[i] = 8'($urandom);
      r = $urandom_range(99);
      if (r < 8) len = 0;
      else if (r < 16) len = 16;
      else if (r < 24) len = $urandom_range(31, 17);
      else if (r < 34) len = 1;
      else len = $urandom_range(15, 2);
      if ($urandom_range(1) == 0) begin
        for (int i = 0; i < 8; i++) begin
          first_v[8*i +: 8] = alpha[$urandom_range(3)];
          next_v[8*i +: 8]  = alpha[$urandom_range(3)];
        end
      end else begin
        first_v = {$urandom, $urandom};
        next_v  = {$urandom, $urandom};
      end
      if ($urandom_range(3) != 0) write_reg(REG_FIRST, first_v);
      if ($urandom_range(3) != 0) write_reg(REG_NEXT, next_v);
      // Junk above the 5-bit length field now and then.
      if ($urandom_range(2) == 0)
        write_reg(REG_LENGTH, ({$urandom, $urandom} & ~64'h1F) | 64'(len));
      else
        write_reg(REG_LENGTH, 64'(len));
      release_bus();

      pat = {needle.next, needle.first};
      eff = (needle.length > CAP) ? CAP : needle.length;
      repeat ($urandom_range(8, 2)) begin
        n = ($urandom_range(99) < 5) ? $urandom_range(160, 41) : $urandom_range(40, 1);
        r = $urandom_range(99);
        if (r < 85 && eff > n) n = eff + $urandom_range(6);
        hay.delete();
        repeat (n) begin
          pick = $urandom_range(9);
          if (pick < 5 && eff > 0) hay.push_back(pat[8*$urandom_range(eff-1) +: 8]);
          else if (pick < 8) hay.push_back(alpha[$urandom_range(3)]);
          else hay.push_back(8'($urandom));
        end
        if (r < 85 && eff > 0) begin
          at = $urandom_range(n - eff);
          for (int i = 0; i < eff; i++) hay[at+i] = pat[8*i +: 8];
          if (r >= 70) hay[at + $urandom_range(eff-1)] ^= 8'(1 << $urandom_range(7));
        end
        foreach (hay[i]) send_word(hay[i], i == hay.size() - 1, 1'b0, '0);
      end
    end

    settle();
    $display("sent %0d words (%0d scanned live) over %0d haystacks, %0d results checked",
             sent_words, live_words, haystacks, results_seen);
    $display("%0d random needle settings, empty through over-length, plus directed cases",
             phases);
    if (errors == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Result side: random back-pressure, checked against the oldest expectation
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    out_ready <= steady || ($urandom_range(99) >= 26);
  end

  always @(posedge clk) begin : check_results
    match_word_t want;
    if (!rst && out_valid && out_ready) begin
      if (expected_matches.size() == 0) begin
        $error("unexpected result word: found=%0b offset=%0d", found, offset);
        errors++;
      end else begin
        want = expected_matches.pop_front();
        if (found !== want.found) begin
          $error("found: expected %0b, got %0b", want.found, found);
          errors++;
        end
        if (offset !== want.offset) begin
          $error("offset: expected %0d, got %0d", want.offset, offset);
          errors++;
        end
        results_seen++;
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("status: fail");
      $finish;
    end
  end

endmodule
`default_nettype wire

>>> filelist.f
+incdir+src
src/fsubm_pkg.sv
src/fsubm_front.sv
src/fsubm_back.sv
src/first_substring_match_top.sv
verif/first_substring_match_top_tb.sv
